// ===== rtl/aadf_pkg.sv =====
// ----------------------------------------------------------------------------
// aadf_pkg
// Shared types, register indexes and command structs for the air data filter.
// ----------------------------------------------------------------------------
package aadf_pkg;

    localparam int NUM_REGS = 7;

    localparam logic [2:0] REG_SPEED_GAIN   = 3'd0;
    localparam logic [2:0] REG_SLIP_GAIN    = 3'd1;
    localparam logic [2:0] REG_ATTACK_GAIN  = 3'd2;
    localparam logic [2:0] REG_ANGLE_LIMIT  = 3'd3;
    localparam logic [2:0] REG_TILT_GAIN    = 3'd4;
    localparam logic [2:0] REG_TILT_LIMIT   = 3'd5;
    localparam logic [2:0] REG_TILT_SPEED   = 3'd6;

    // datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_RD_OLD   = 4'd1,  // read entry leaving full window and short window
        OP_UPD_SUMS = 4'd2,  // update running sums for current channel
        OP_DIV_NEW  = 4'd3,  // start mean of newest samples
        OP_DIV_OLD  = 4'd4,  // start mean of older samples
        OP_FACTOR   = 4'd5,  // |diff| * gain, clamp
        OP_SMOOTH   = 4'd6,  // prev + factor*(x-prev)
        OP_SCALE    = 4'd7,  // compute scaled angle for next channel
        OP_TILT_SM  = 4'd8,
        OP_TILT_NRM = 4'd9,
        OP_TILT_PWR = 4'd10,
        OP_TILT_ACC = 4'd11,
        OP_COMMIT   = 4'd12
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

endpackage

// ===== rtl/aadf_ram.sv =====
// ----------------------------------------------------------------------------
// aadf_ram
// Generic single write port, dual read port RAM with registered reads.
// ----------------------------------------------------------------------------
module aadf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ===== rtl/aadf_div.sv =====
// ----------------------------------------------------------------------------
// aadf_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module aadf_div
    import aadf_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_busy,
    output logic signed [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic [DEN_W:0]   w_try;

    always_comb begin
        w_try = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_q   = {r_q[NUM_W-2:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem   = w_try - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_q   <= i_num[NUM_W-1] ? -i_num : i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ===== rtl/aadf_ctrl.sv =====
// ----------------------------------------------------------------------------
// aadf_ctrl
// Sequencer: walks the three channels through sums, means, factor and smoothing,
// then the tilt path, and hands the result to the output register.
// ----------------------------------------------------------------------------
module aadf_ctrl
    import aadf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_load,
    output logic    o_done,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_RD     = 14'b00000000000010,
        S_SUMS   = 14'b00000000000100,
        S_DNEW   = 14'b00000000001000,
        S_WNEW   = 14'b00000000010000,
        S_DOLD   = 14'b00000000100000,
        S_WOLD   = 14'b00000001000000,
        S_FACT   = 14'b00000010000000,
        S_SMTH   = 14'b00000100000000,
        S_SCALE  = 14'b00001000000000,
        S_TSM    = 14'b00010000000000,
        S_TNRM   = 14'b00100000000000,
        S_TPWR   = 14'b01000000000000,
        S_TACC   = 14'b10000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_chan, n_chan;
    logic       r_wait;
    logic       n_wait;

    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        n_wait  = 1'b0;
        o_cmd   = '{op: OP_NONE, chan: r_chan};
        o_ready = 1'b0;
        o_load  = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = i_out_free;
                if (i_valid && i_out_free) begin
                    o_load  = 1'b1;
                    n_chan  = 2'd0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.op = OP_RD_OLD;
                n_state  = S_SUMS;
            end
            S_SUMS: begin
                o_cmd.op = OP_UPD_SUMS;
                n_state  = S_DNEW;
            end
            S_DNEW: begin
                o_cmd.op = OP_DIV_NEW;
                n_state  = S_WNEW;
                n_wait   = 1'b1;
            end
            S_WNEW: begin
                if (!r_wait && !i_status.div_busy) n_state = S_DOLD;
            end
            S_DOLD: begin
                o_cmd.op = OP_DIV_OLD;
                n_state  = S_WOLD;
                n_wait   = 1'b1;
            end
            S_WOLD: begin
                if (!r_wait && !i_status.div_busy) n_state = S_FACT;
            end
            S_FACT: begin
                o_cmd.op = OP_FACTOR;
                n_state  = S_SMTH;
            end
            S_SMTH: begin
                o_cmd.op = OP_SMOOTH;
                if (r_chan == 2'd2) begin
                    n_state = S_TSM;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_chan   = r_chan + 2'd1;
                n_state  = S_RD;
            end
            S_TSM: begin
                o_cmd.op = OP_TILT_SM;
                n_state  = S_TNRM;
            end
            S_TNRM: begin
                o_cmd.op = OP_TILT_NRM;
                n_state  = S_TPWR;
            end
            S_TPWR: begin
                o_cmd.op = OP_TILT_PWR;
                n_state  = S_TACC;
            end
            S_TACC: begin
                o_cmd.op = OP_TILT_ACC;
                o_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= 2'd0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_wait  <= n_wait;
        end
    end
endmodule

// ===== rtl/aadf_dp.sv =====
// ----------------------------------------------------------------------------
// aadf_dp
// Datapath: windows, running sums, shared multiplier and divider, filter state
// and tilt integrator.
// ----------------------------------------------------------------------------
module aadf_dp
    import aadf_pkg::*;
#(
    parameter int SHORT_WINDOW  = 40,
    parameter int LONG_WINDOW   = 80,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_done,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [31:0] i_raw_airspeed,
    input  logic signed [31:0] i_raw_sideslip,
    input  logic signed [31:0] i_raw_attack,
    input  logic [16:0]        i_speed_gain,
    input  logic [16:0]        i_sideslip_gain,
    input  logic [16:0]        i_attack_gain,
    input  logic [23:0]        i_angle_valid_limit,
    input  logic [16:0]        i_tilt_gain,
    input  logic [16:0]        i_tilt_limit,
    input  logic [21:0]        i_tilt_enable_speed,
    output logic signed [31:0] o_filtered_airspeed,
    output logic signed [31:0] o_filtered_sideslip,
    output logic signed [31:0] o_filtered_attack,
    output logic signed [17:0] o_tilt_command
);
    localparam int F       = FRACTION_BITS;
    localparam int SE      = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int AW      = $clog2(LONG_WINDOW);
    localparam int CW      = $clog2(LONG_WINDOW + 1);
    localparam int SW      = 32 + CW + 1;
    localparam int DW      = CW + 1;
    localparam longint QONE = 64'sd1 <<< F;
    localparam longint QHALF = 64'sd1 <<< (F - 1);
    localparam longint QMIN  = (QONE + 50) / 100;
    localparam longint QSMO  = (QONE * 7 + 500) / 1000;
    localparam longint QNRM  = (QONE * 4 + 50) / 100;

    // input and per-tick registers
    logic signed [31:0] r_raw [3];
    logic signed [31:0] r_x;            // sample being windowed
    logic signed [31:0] r_prev [3];
    logic signed [31:0] r_new [3];
    logic signed [SW-1:0] r_sum_all [3];
    logic signed [SW-1:0] r_sum_new [3];
    logic signed [31:0] r_mean_new;
    logic signed [63:0] r_diff;
    logic signed [31:0] r_factor;
    logic signed [31:0] r_smooth;
    logic signed [31:0] r_norm;
    logic signed [31:0] r_power;
    logic signed [31:0] r_tilt;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_wpos;
    logic               r_angle_bad;

    logic [CW-1:0] w_count;
    logic [CW-1:0] w_nnew, w_nold;
    logic [AW-1:0] w_leave;
    logic [31:0]   w_rd_all [3];
    logic [31:0]   w_rd_new [3];

    assign w_count = (r_count < CW'(LONG_WINDOW)) ? r_count + 1'b1 : CW'(LONG_WINDOW);
    assign w_nnew  = (w_count < CW'(SE)) ? w_count : CW'(SE);
    assign w_nold  = w_count - w_nnew;
    // entry that drops out of the newest window, wrapped around the history
    assign w_leave = (r_wpos >= AW'(SE)) ? r_wpos - AW'(SE)
                                         : r_wpos + AW'(LONG_WINDOW - SE);

    for (genvar c = 0; c < 3; c++) begin : g_win
        aadf_ram #(.WIDTH(32), .DEPTH(LONG_WINDOW)) u_ram (
            .i_clk    (i_clk),
            .i_we     (i_cmd.op == OP_UPD_SUMS && i_cmd.chan == 2'(c)),
            .i_waddr  (r_wpos),
            .i_wdata  (r_x),
            .i_raddr_a(r_wpos),
            .i_raddr_b(w_leave),
            .o_rdata_a(w_rd_all[c]),
            .o_rdata_b(w_rd_new[c])
        );
    end

    // shared divider
    logic                 w_div_start;
    logic signed [SW-1:0] w_div_num;
    logic [DW-1:0]        w_div_den;
    logic signed [SW-1:0] w_quot;
    logic                 w_div_busy;
    logic signed [SW-1:0] w_sa, w_sn;

    assign w_sa = r_sum_all[i_cmd.chan];
    assign w_sn = r_sum_new[i_cmd.chan];
    assign w_div_start = (i_cmd.op == OP_DIV_NEW) || (i_cmd.op == OP_DIV_OLD);
    assign w_div_num   = (i_cmd.op == OP_DIV_NEW) ? w_sn : w_sa - w_sn;
    assign w_div_den   = (i_cmd.op == OP_DIV_NEW) ? DW'(w_nnew)
                       : ((w_nold == '0) ? DW'(1) : DW'(w_nold));

    aadf_div #(.NUM_W(SW), .DEN_W(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_busy (w_div_busy),
        .o_quot (w_quot)
    );
    assign o_status.div_busy = w_div_busy;

    // one shared signed multiplier with floor shift
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic signed [67:0] w_sh;
    logic signed [31:0] w_gain;
    logic signed [32:0] w_delta;
    logic signed [31:0] w_scale;
    logic signed [31:0] w_spd;
    logic signed [33:0] w_diffc;

    assign w_spd = r_new[0];
    always_comb begin
        case (i_cmd.chan)
            2'd0:    w_gain = 32'(i_speed_gain);
            2'd1:    w_gain = 32'(i_sideslip_gain);
            default: w_gain = 32'(i_attack_gain);
        endcase
        w_delta = 33'(r_x) - 33'(r_prev[i_cmd.chan]);
        // mean difference is below 2^32, so it fits the multiplier operand
        w_diffc = 34'(r_diff);
        // scale for the next channel after filtered airspeed is known
        if (i_cmd.chan == 2'd0) begin
            if (r_angle_bad) w_scale = '0;
            else if (w_spd < 32'(3 * QONE)) w_scale = '0;
            else if (w_spd > 32'(5 * QONE)) w_scale = 32'(QONE);
            else w_scale = (w_spd - 32'(3 * QONE)) >>> 1;
        end else begin
            if (w_spd < 32'(QONE)) w_scale = '0;
            else if (w_spd > 32'(3 * QONE)) w_scale = 32'(QONE);
            else w_scale = (w_spd - 32'(QONE)) >>> 1;
        end
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_FACTOR: begin
                w_ma = w_diffc;
                w_mb = 34'(w_gain);
            end
            OP_SMOOTH: begin
                w_ma = 34'(w_delta);
                w_mb = 34'(r_factor);
            end
            OP_SCALE: begin
                w_ma = 34'(r_raw[i_cmd.chan + 2'd1]);
                w_mb = 34'(w_scale);
            end
            OP_TILT_SM: begin
                w_ma = 34'(33'(r_x) - 33'(r_prev[2]));
                w_mb = 34'(QSMO);
            end
            OP_TILT_NRM: begin
                w_ma = 34'(r_smooth);
                w_mb = 34'(QNRM);
            end
            OP_TILT_PWR: begin
                w_ma = 34'(r_norm);
                w_mb = 34'(r_norm);
            end
            OP_TILT_ACC: begin
                w_ma = 34'(r_power);
                w_mb = 34'(i_tilt_gain);
            end
            default: ;
        endcase
        w_prod = w_ma * w_mb;
        w_sh   = w_prod >>> F;
    end

    logic signed [63:0] w_fac;
    logic signed [35:0] w_acc;
    logic signed [31:0] w_sm;
    logic               w_bad;
    logic signed [32:0] w_abs_s, w_abs_a;

    assign w_abs_s = i_raw_sideslip[31] ? -33'(i_raw_sideslip) : 33'(i_raw_sideslip);
    assign w_abs_a = i_raw_attack[31] ? -33'(i_raw_attack) : 33'(i_raw_attack);
    assign w_bad   = (w_abs_s > 33'(i_angle_valid_limit)) || (w_abs_a > 33'(i_angle_valid_limit));
    assign w_fac   = 64'(w_sh);
    assign w_sm    = r_x + 32'(w_sh);
    assign w_acc   = 36'(r_tilt) - 36'(w_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wpos  <= '0;
            r_tilt  <= '0;
            for (int c = 0; c < 3; c++) begin
                r_prev[c]    <= '0;
                r_sum_all[c] <= '0;
                r_sum_new[c] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_UPD_SUMS: begin
                    r_sum_all[i_cmd.chan] <= w_sa + SW'(r_x)
                        - ((r_count >= CW'(LONG_WINDOW)) ? SW'($signed(w_rd_all[i_cmd.chan])) : '0);
                    r_sum_new[i_cmd.chan] <= w_sn + SW'(r_x)
                        - ((r_count >= CW'(SE)) ? SW'($signed(w_rd_new[i_cmd.chan])) : '0);
                end
                OP_TILT_ACC: begin
                    if (w_spd < $signed(32'(i_tilt_enable_speed))) begin
                        r_tilt <= '0;
                    end else if (w_acc > $signed(36'(i_tilt_limit))) begin
                        r_tilt <= 32'(i_tilt_limit);
                    end else if (w_acc < -$signed(36'(i_tilt_limit))) begin
                        r_tilt <= -32'(i_tilt_limit);
                    end else begin
                        r_tilt <= 32'(w_acc);
                    end
                end
                default: ;
            endcase
            if (i_done) begin
                r_count <= w_count;
                r_wpos  <= (r_wpos == AW'(LONG_WINDOW - 1)) ? '0 : r_wpos + 1'b1;
                for (int c = 0; c < 3; c++) r_prev[c] <= r_new[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw[0]    <= i_raw_airspeed;
            r_raw[1]    <= i_raw_sideslip;
            r_raw[2]    <= i_raw_attack;
            r_x         <= i_raw_airspeed;
            r_angle_bad <= w_bad;
        end
        case (i_cmd.op)
            OP_DIV_OLD: r_mean_new <= 32'(w_quot);
            OP_FACTOR: ;
            OP_SCALE: r_x <= 32'(w_sh);
            OP_TILT_SM: r_smooth <= r_prev[2] + 32'(w_sh);
            OP_TILT_NRM: begin
                if (w_sh > 68'(QONE)) r_norm <= 32'(QONE);
                else if (w_sh < -68'(QONE)) r_norm <= -32'(QONE);
                else r_norm <= 32'(w_sh);
            end
            OP_TILT_PWR: r_power <= (r_norm <= 0) ? -32'(w_sh) : 32'(w_sh);
            default: ;
        endcase
        if (i_cmd.op == OP_FACTOR) begin
            if (w_nold == '0) r_factor <= 32'(QHALF);
            else if (w_fac < 64'(QMIN)) r_factor <= 32'(QMIN);
            else if (w_fac > 64'(QHALF)) r_factor <= 32'(QHALF);
            else r_factor <= 32'(w_fac);
        end
        if (i_cmd.op == OP_SMOOTH) begin
            r_new[i_cmd.chan] <= r_prev[i_cmd.chan] + 32'(w_sh);
        end
    end

    // |old mean - new mean| once the older mean is out of the divider
    always_ff @(posedge i_clk) begin
        if (o_status.div_busy == 1'b0) begin
            r_diff <= (64'(w_quot) - 64'(r_mean_new) < 0)
                    ? 64'(r_mean_new) - 64'(w_quot) : 64'(w_quot) - 64'(r_mean_new);
        end
    end

    assign o_filtered_airspeed = r_new[0];
    assign o_filtered_sideslip = r_new[1];
    assign o_filtered_attack   = r_new[2];
    assign o_tilt_command      = 18'(r_tilt);
endmodule

// ===== rtl/adaptive_air_data_filter_top.sv =====
// running sums are SW = 40 bits wide; a request is accepted only in idle, so a new
// request waits until the previous one is done; the bit-serial divider sets the pace
// the divider runs twice per channel, for the two window means
// a new request waits while a finished result still occupies the output register
// reset: synchronous active-low; clears windows count, sums, filter state, tilt
// and restores register defaults
// ----------------------------------------------------------------------------
// adaptive_air_data_filter_top
// Adaptive smoothing of airspeed and scaled angles with probe tilt command.
// ----------------------------------------------------------------------------
module adaptive_air_data_filter_top
    import aadf_pkg::*;
#(
    parameter int SHORT_WINDOW  = 40,
    parameter int LONG_WINDOW   = 80,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_raw_airspeed,
    input  logic signed [31:0] i_raw_sideslip,
    input  logic signed [31:0] i_raw_attack,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_filtered_airspeed,
    output logic signed [31:0] o_filtered_sideslip,
    output logic signed [31:0] o_filtered_attack,
    output logic signed [17:0] o_tilt_command,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    logic [16:0] r_speed_gain, r_slip_gain, r_attack_gain, r_tilt_gain, r_tilt_limit;
    logic [23:0] r_angle_limit;
    logic [21:0] r_tilt_speed;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain  <= 17'd655;
            r_slip_gain   <= 17'd1180;
            r_attack_gain <= 17'd786;
            r_angle_limit <= 24'd1835008;
            r_tilt_gain   <= 17'd328;
            r_tilt_limit  <= 17'd39322;
            r_tilt_speed  <= 22'd131072;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SPEED_GAIN:  r_speed_gain  <= i_cfg_data[16:0];
                REG_SLIP_GAIN:   r_slip_gain   <= i_cfg_data[16:0];
                REG_ATTACK_GAIN: r_attack_gain <= i_cfg_data[16:0];
                REG_ANGLE_LIMIT: r_angle_limit <= i_cfg_data[23:0];
                REG_TILT_GAIN:   r_tilt_gain   <= i_cfg_data[16:0];
                REG_TILT_LIMIT:  r_tilt_limit  <= i_cfg_data[16:0];
                REG_TILT_SPEED:  r_tilt_speed  <= i_cfg_data[21:0];
                default: ;
            endcase
        end
    end

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_load, w_done;
    logic signed [31:0] w_fa, w_fs, w_fat;
    logic signed [17:0] w_tc;
    logic    r_out_valid;
    logic    r_fin;

    // a result on its way into the output register still counts as occupying it
    aadf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .o_load    (w_load),
        .o_done    (w_done),
        .i_out_free((!r_out_valid || i_ready) && !r_fin),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    aadf_dp #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .LONG_WINDOW  (LONG_WINDOW),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (w_load),
        .i_done             (w_done),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_raw_airspeed     (i_raw_airspeed),
        .i_raw_sideslip     (i_raw_sideslip),
        .i_raw_attack       (i_raw_attack),
        .i_speed_gain       (r_speed_gain),
        .i_sideslip_gain    (r_slip_gain),
        .i_attack_gain      (r_attack_gain),
        .i_angle_valid_limit(r_angle_limit),
        .i_tilt_gain        (r_tilt_gain),
        .i_tilt_limit       (r_tilt_limit),
        .i_tilt_enable_speed(r_tilt_speed),
        .o_filtered_airspeed(w_fa),
        .o_filtered_sideslip(w_fs),
        .o_filtered_attack  (w_fat),
        .o_tilt_command     (w_tc)
    );

    // result register, loaded in the cycle after the tilt step finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_fin <= w_done;
            if (r_fin) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
        if (r_fin) begin
            o_filtered_airspeed <= w_fa;
            o_filtered_sideslip <= w_fs;
            o_filtered_attack   <= w_fat;
            o_tilt_command      <= w_tc;
        end
    end
    assign o_valid = r_out_valid;
endmodule

// ===== rtl/aadf_checker.sv =====
// ----------------------------------------------------------------------------
// aadf_checker
// Port-level checks for the air data filter.
// ----------------------------------------------------------------------------
module aadf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [17:0] o_tilt_command
);
    // output valid and tilt command held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tilt_command))
        else $error("result dropped while stalled");

    // a request is never taken while a result stalls
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken over stalled result");

    // no result right after acceptance
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result too early");

    // tilt stays at or above the negative of the widest limit
    a_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tilt_command >= -18'sd131071))
        else $error("tilt out of range");
endmodule

bind adaptive_air_data_filter_top aadf_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_tilt_command(o_tilt_command)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the adaptive air data filter against a cycle-free predictor: directed
// edge cases, register sweeps, random flight segments, and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import aadf_pkg::*;

    localparam int  SHORT_LEN = 40;
    localparam int  LONG_LEN  = 80;
    localparam int  FB        = 16;
    localparam longint Q1     = 64'sd1 << FB;
    localparam longint QHALF  = 64'sd1 << (FB - 1);
    localparam longint QMINF  = (Q1 + 50) / 100;
    localparam longint QSLOW  = (Q1 * 7 + 500) / 1000;
    localparam longint QNORM  = (Q1 * 4 + 50) / 100;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic signed [31:0] airspeed;
        logic signed [31:0] sideslip;
        logic signed [31:0] attack;
        logic signed [17:0] tilt;
    } t_air_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_raw_airspeed = '0;
    logic signed [31:0] i_raw_sideslip = '0;
    logic signed [31:0] i_raw_attack = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_filtered_airspeed;
    logic signed [31:0] o_filtered_sideslip;
    logic signed [31:0] o_filtered_attack;
    logic signed [17:0] o_tilt_command;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    adaptive_air_data_filter_top dut (.*);

    always #4 i_clk = ~i_clk;

    // filter state mirror
    longint      reg_val [NUM_REGS];
    int unsigned reg_bits [NUM_REGS] = '{17, 17, 17, 24, 17, 17, 22};
    longint      hist [3][LONG_LEN];
    longint      sum_all [3];
    longint      sum_new [3];
    longint      prev_filt [3];
    longint      tilt_acc;
    int          fill_cnt;
    int          wr_pos;

    t_air_result pending_results[$];
    int          ticks_sent;
    int          results_checked;
    int          mismatches;
    int          rx_hold_cycles;
    bit          sender_gaps = 1'b1;

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FB;
    endfunction

    function automatic void clear_filter_state();
        reg_val = '{655, 1180, 786, 1835008, 328, 39322, 131072};
        foreach (hist[c, k]) hist[c][k] = 0;
        foreach (sum_all[c]) begin
            sum_all[c] = 0;
            sum_new[c] = 0;
            prev_filt[c] = 0;
        end
        tilt_acc = 0;
        fill_cnt = 0;
        wr_pos = 0;
    endfunction

    function automatic void push_sample(int ch, longint x);
        int leave;
        leave = (wr_pos + LONG_LEN - SHORT_LEN) % LONG_LEN;
        if (fill_cnt >= LONG_LEN) sum_all[ch] -= hist[ch][wr_pos];
        if (fill_cnt >= SHORT_LEN) sum_new[ch] -= hist[ch][leave];
        hist[ch][wr_pos] = x;
        sum_all[ch] += x;
        sum_new[ch] += x;
    endfunction

    function automatic longint smoothing_factor(int ch, int count, longint gain);
        int     n_new;
        int     n_old;
        longint diff;
        n_new = count < SHORT_LEN ? count : SHORT_LEN;
        n_old = count - n_new;
        // warm-up: nothing older than the short window yet
        if (n_old == 0) return QHALF;
        diff = (sum_all[ch] - sum_new[ch]) / n_old - sum_new[ch] / n_new;
        if (diff < 0) diff = -diff;
        return clampl(qmul(diff, gain), QMINF, QHALF);
    endfunction

    function automatic t_air_result predict_filter_tick(logic signed [31:0] a,
            logic signed [31:0] s, logic signed [31:0] t);
        t_air_result r;
        longint raw_s, raw_t, lim, speed, slip_scale, aoa_scale;
        longint slip_x, aoa_x, slip_f, aoa_f, slow, norm, power;
        int     count;
        raw_s = s;
        raw_t = t;
        lim = reg_val[REG_ANGLE_LIMIT];
        count = fill_cnt < LONG_LEN ? fill_cnt + 1 : LONG_LEN;

        push_sample(0, longint'(a));
        speed = prev_filt[0] + qmul(longint'(a) - prev_filt[0],
                                    smoothing_factor(0, count, reg_val[REG_SPEED_GAIN]));

        if (raw_s > lim || -raw_s > lim || raw_t > lim || -raw_t > lim) slip_scale = 0;
        else slip_scale = (clampl(speed, 3 * Q1, 5 * Q1) - 3 * Q1) >>> 1;
        slip_x = qmul(raw_s, slip_scale);
        push_sample(1, slip_x);
        slip_f = prev_filt[1] + qmul(slip_x - prev_filt[1],
                                     smoothing_factor(1, count, reg_val[REG_SLIP_GAIN]));

        aoa_scale = (clampl(speed, Q1, 3 * Q1) - Q1) >>> 1;
        aoa_x = qmul(raw_t, aoa_scale);
        push_sample(2, aoa_x);
        aoa_f = prev_filt[2] + qmul(aoa_x - prev_filt[2],
                                    smoothing_factor(2, count, reg_val[REG_ATTACK_GAIN]));

        slow = prev_filt[2] + qmul(aoa_x - prev_filt[2], QSLOW);
        norm = clampl(qmul(slow, QNORM), -Q1, Q1);
        power = qmul(norm, norm);
        if (norm <= 0) power = -power;
        if (speed < reg_val[REG_TILT_SPEED]) tilt_acc = 0;
        else tilt_acc -= qmul(power, reg_val[REG_TILT_GAIN]);
        tilt_acc = clampl(tilt_acc, -reg_val[REG_TILT_LIMIT], reg_val[REG_TILT_LIMIT]);

        fill_cnt = count;
        wr_pos = (wr_pos + 1) % LONG_LEN;
        prev_filt[0] = speed;
        prev_filt[1] = slip_f;
        prev_filt[2] = aoa_f;

        r.airspeed = speed[31:0];
        r.sideslip = slip_f[31:0];
        r.attack = aoa_f[31:0];
        r.tilt = tilt_acc[17:0];
        return r;
    endfunction

    function automatic int pick_gap(bit long_ok);
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 88) return $urandom_range(1, 4);
        if (p < 97 || !long_ok) return $urandom_range(5, 20);
        return $urandom_range(30, 90);
    endfunction

    // receiver: random ready pattern, or a counted hold-off when requested
    int rx_run;
    bit rx_level;
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_ready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else if (rx_run > 0) begin
            rx_run <= rx_run - 1;
        end else begin
            rx_level = ($urandom_range(0, 9) < 7);
            i_ready <= rx_level;
            rx_run <= rx_level ? $urandom_range(1, 30) : pick_gap(1'b1);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_air_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (o_filtered_airspeed !== exp_r.airspeed) begin
                    $display("%0t: airspeed exp %0d got %0d", $time,
                             exp_r.airspeed, o_filtered_airspeed);
                    mismatches++;
                end
                if (o_filtered_sideslip !== exp_r.sideslip) begin
                    $display("%0t: sideslip exp %0d got %0d", $time,
                             exp_r.sideslip, o_filtered_sideslip);
                    mismatches++;
                end
                if (o_filtered_attack !== exp_r.attack) begin
                    $display("%0t: attack exp %0d got %0d", $time,
                             exp_r.attack, o_filtered_attack);
                    mismatches++;
                end
                if (o_tilt_command !== exp_r.tilt) begin
                    $display("%0t: tilt exp %0d got %0d", $time,
                             exp_r.tilt, o_tilt_command);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_tick(logic signed [31:0] a, logic signed [31:0] s,
                             logic signed [31:0] t);
        int          gap;
        t_air_result exp_r;
        i_valid <= 1'b1;
        i_raw_airspeed <= a;
        i_raw_sideslip <= s;
        i_raw_attack <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        exp_r = predict_filter_tick(a, s, t);
        pending_results.insert(pending_results.size(), exp_r);
        ticks_sent++;
        gap = sender_gaps ? pick_gap(1'b1) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // lower valid and wait for every outstanding result
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < NUM_REGS) reg_val[idx] = longint'(data) & ((64'sd1 << reg_bits[idx]) - 1);
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
            logic [31:0] d3, logic [31:0] d4, logic [31:0] d5, logic [31:0] d6);
        drain_results();
        write_reg(REG_SPEED_GAIN, d0);
        write_reg(REG_SLIP_GAIN, d1);
        write_reg(REG_ATTACK_GAIN, d2);
        write_reg(REG_ANGLE_LIMIT, d3);
        write_reg(REG_TILT_GAIN, d4);
        write_reg(REG_TILT_LIMIT, d5);
        write_reg(REG_TILT_SPEED, d6);
    endtask

    function automatic logic signed [31:0] deg(int lo, int hi);
        return $signed($urandom_range(0, (hi - lo) * 65536)) + lo * 65536;
    endfunction

    // a flight segment: drifting speed and biased angles, some full-range noise
    task automatic fly_segment(int n);
        int speed, slip_bias, aoa_bias;
        speed = $urandom_range(0, 7 * 65536);
        slip_bias = deg(-20, 20);
        aoa_bias = deg(-25, 25);
        repeat (n) begin
            if ($urandom_range(0, 99) < 12) begin
                send_tick($urandom, $urandom, $urandom);
            end else begin
                speed += $signed($urandom_range(0, 32768)) - 16384;
                if ($urandom_range(0, 29) == 0) speed = $urandom_range(0, 7 * 65536);
                send_tick(speed + deg(-1, 1), slip_bias + deg(-6, 6), aoa_bias + deg(-6, 6));
            end
        end
    endtask

    task automatic test_directed_edges();
        // zero, extremes, speed scale corners, angle limit edges
        send_tick(0, 0, 0);
        send_tick(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_tick(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_tick(32'sh7fffffff, 32'sh80000000, 32'sh00000001);
        send_tick(-1, -1, -1);
        send_tick(0, 0, 0);
        repeat (4) send_tick(65536, 10 * 65536, 10 * 65536);
        repeat (4) send_tick(3 * 65536, 28 * 65536, -28 * 65536);
        repeat (4) send_tick(5 * 65536, 1835008, -1835008);
        send_tick(6 * 65536, 1835009, 0);
        send_tick(6 * 65536, 0, -1835009);
        send_tick(8 * 65536, -1835008, 1835008);
        send_tick(8 * 65536, 30 * 65536, 40 * 65536);
        send_tick(131071, 5 * 65536, 20 * 65536);
        send_tick(2 * 65536, -5 * 65536, -20 * 65536);
    endtask

    task automatic test_register_sweep();
        write_all_regs(0, 0, 0, 0, 0, 0, 0);
        fly_segment(40);
        write_all_regs(65536, 65536, 65536, 11796480, 65536, 65536, 3276800);
        fly_segment(40);
        write_all_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                       32'hffffffff, 32'hffffffff, 32'hffffffff);
        fly_segment(40);
        write_all_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        fly_segment(40);
        write_all_regs(65536, 40000, 20000, 25 * 65536, 65536, 65536, 0);
        fly_segment(40);
        drain_results();
        write_reg(REG_UNUSED, 32'h12345678);
        write_all_regs(655, 1180, 786, 1835008, 328, 39322, 131072);
    endtask

    task automatic test_random_flight();
        repeat (10) begin
            fly_segment($urandom_range(40, 100));
            if ($urandom_range(0, 3) == 0) begin
                write_all_regs($urandom_range(0, 65536), $urandom_range(0, 65536),
                               $urandom_range(0, 65536), $urandom_range(0, 11796480),
                               $urandom_range(0, 65536), $urandom_range(0, 65536),
                               $urandom_range(0, 3276800));
            end
        end
        sender_gaps = 1'b0;
        fly_segment(60);
        sender_gaps = 1'b1;
    endtask

    task automatic test_receiver_stall();
        drain_results();
        rx_hold_cycles = 1500;
        sender_gaps = 1'b0;
        fly_segment(20);
        sender_gaps = 1'b1;
    endtask

    task automatic test_sender_pause();
        fly_segment(10);
        drain_results();
        fly_segment(10);
    endtask

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        clear_filter_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_register_sweep();
        test_random_flight();
        test_receiver_stall();
        test_sender_pause();
        drain_results();
        repeat (400) @(posedge i_clk);
        $display("filter ticks sent %0d, results checked %0d, mismatches %0d",
                 ticks_sent, results_checked, mismatches);
        $display("covered: input extremes, angle limit edges, register sweeps, stalls");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
